@@ rtl/brsp_pkg.sv @@
// Shared package for the banked ROM / shadow RAM pager.
// Holds the operation codes, the memory map constants and the stage types.
// Depends on nothing; the pager imports it, while brsp_ram depends on no package.
package brsp_pkg;

  // Sizes of the internal store and of one ROM page.
  localparam int unsigned StoreBytes = 65536;
  localparam int unsigned PageBytes  = 16384;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned PageW      = $clog2(PageBytes);
  localparam int unsigned ByteW      = 8;

  // Latch bit positions.
  localparam int unsigned BitUnmap  = 1;
  localparam int unsigned BitPage   = 3;
  localparam int unsigned BitShadow = 5;

  // Operation codes of one input beat.
  typedef enum logic [2:0] {
    OP_PORT_WRITE = 3'd0,
    OP_READ       = 3'd1,
    OP_WRITE      = 3'd2,
    OP_LOAD       = 3'd3,
    OP_NMI        = 3'd4,
    OP_BANK_READ  = 3'd5,
    OP_BANK_WRITE = 3'd6
  } op_t;

  // Result held between the store access and the output register.
  typedef struct packed {
    logic             mem_read;
    logic [ByteW-1:0] byte_val;
    logic             from_internal;
    logic             forward_write;
    logic [ByteW-1:0] latch_now;
  } stage_t;

endpackage

@@ rtl/brsp_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// Used for the internal store; depends on no package.
module brsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/banked_rom_shadow_ram_pager.sv @@
// Paging interface: an 8-bit bit-addressable latch selects ROM pages and shadow RAM held
// in a 64 KiB internal store. One beat is accepted per clock cycle while in_stall is low;
// its result passes stage 1, which catches the single-port store's registered read, into
// the output register. Each beat makes at most one store access, so back-to-back reads and
// writes of the same byte need no forwarding. The store holds no reset value: bytes must be
// loaded or written before they are read.
module banked_rom_shadow_ram_pager
  import brsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [15:0]      in_address,
  input  logic [7:0]       in_data,
  input  logic [7:0]       in_lower_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_from_internal,
  output logic             out_forward_write,
  output logic [7:0]       out_latch_now
);

  logic [ByteW-1:0] latch_r, latch_nxt;
  logic             s1_valid_r;
  stage_t           s1_r, s1_nxt;
  logic             o_valid_r;
  logic [ByteW-1:0] o_read_r;
  logic             o_int_r, o_fwd_r;
  logic [ByteW-1:0] o_latch_r;

  logic             accept, s1_move;
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [ByteW-1:0] mem_q;
  logic             hi_area, rom_area, shadow;
  op_t              op;

  assign op       = op_t'(in_op);
  assign shadow   = latch_r[BitShadow];
  assign hi_area  = in_address[AddrW-1];
  assign rom_area = (in_address[AddrW-1:PageW] == '0);

  // Handshake: stage 1 drains into the output register whenever that is free.
  assign s1_move  = s1_valid_r && (!o_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign accept   = in_valid && !in_stall;

  // Decode the beat: latch update, store access and the pass-through result.
  always_comb begin
    latch_nxt            = latch_r;
    mem_en               = 1'b0;
    mem_we               = 1'b0;
    mem_addr             = in_address[AddrW-1:0];
    s1_nxt.mem_read      = 1'b0;
    s1_nxt.byte_val      = '0;
    s1_nxt.from_internal = 1'b0;
    s1_nxt.forward_write = 1'b0;
    unique case (op)
      OP_PORT_WRITE: latch_nxt[in_data[3:1]] = in_data[0];
      OP_READ: begin
        if (rom_area && !latch_r[BitUnmap]) begin
          mem_en   = 1'b1;
          mem_addr = {1'b0, latch_r[BitPage], in_address[PageW-1:0]};
          s1_nxt.mem_read      = 1'b1;
          s1_nxt.from_internal = 1'b1;
        end else if (hi_area && shadow) begin
          mem_en               = 1'b1;
          s1_nxt.mem_read      = 1'b1;
          s1_nxt.from_internal = 1'b1;
        end else begin
          s1_nxt.byte_val = in_lower_data;
        end
      end
      OP_WRITE: begin
        if (hi_area && shadow) begin
          mem_en               = 1'b1;
          mem_we               = 1'b1;
          s1_nxt.from_internal = 1'b1;
        end else begin
          s1_nxt.forward_write = 1'b1;
        end
      end
      OP_LOAD: begin
        mem_en               = 1'b1;
        mem_we               = 1'b1;
        s1_nxt.from_internal = 1'b1;
      end
      OP_NMI: latch_nxt = '0;
      OP_BANK_READ: begin
        if (hi_area && !shadow) begin
          mem_en               = 1'b1;
          s1_nxt.mem_read      = 1'b1;
          s1_nxt.from_internal = 1'b1;
        end else begin
          s1_nxt.byte_val = in_lower_data;
        end
      end
      OP_BANK_WRITE: begin
        if (hi_area && !shadow) begin
          mem_en               = 1'b1;
          mem_we               = 1'b1;
          s1_nxt.from_internal = 1'b1;
        end else begin
          s1_nxt.forward_write = 1'b1;
        end
      end
      default: ;
    endcase
    s1_nxt.latch_now = latch_nxt;
  end

  // Internal store; the read port only moves on an accepted beat.
  brsp_ram #(
    .WIDTH(ByteW),
    .DEPTH(StoreBytes)
  ) u_store (
    .clk  (clk),
    .en   (mem_en && accept),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(in_data),
    .rdata(mem_q)
  );

  // Control registers: latch, stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r    <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        latch_r <= latch_nxt;
      end
      s1_valid_r <= accept || (s1_valid_r && !s1_move);
      if (s1_move) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      o_read_r  <= s1_r.mem_read ? mem_q : s1_r.byte_val;
      o_int_r   <= s1_r.from_internal;
      o_fwd_r   <= s1_r.forward_write;
      o_latch_r <= s1_r.latch_now;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_read_data     = o_read_r;
  assign out_from_internal = o_int_r;
  assign out_forward_write = o_fwd_r;
  assign out_latch_now     = o_latch_r;

`ifndef NO_ASSERTIONS
  // A beat is never both served internally and forwarded.
  a_int_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_from_internal && out_forward_write))
    else $error("result both internal and forwarded");

  // An accepted NMI leaves a cleared latch.
  a_nmi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_NMI) |=> (latch_r == '0 && s1_r.latch_now == '0))
    else $error("latch not cleared by NMI");

  // A stalled stage 1 holds its beat and blocks the input.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 lost or changed a beat");

  // Every store read belongs to an accepted beat that goes to stage 1.
  a_mem_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mem_en && !mem_we) |=> (s1_valid_r && s1_r.mem_read))
    else $error("store read not tracked");
`endif

endmodule
